/* design/rar_pkg.sv */
// shared types and constants for the rational arithmetic reduce unit
package rar_pkg;
    localparam int OperandWidth = 32;

    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2,
        MODE_DIV = 2'd3
    } t_mode;

    // queue entry from front to back: signed magnitudes of raw result
    typedef struct packed {
        logic        zero;
        logic        neg;
        logic [63:0] num_mag;
        logic [63:0] den_mag;
    } t_job;
endpackage

/* design/rar_if.sv */
// valid/ready channel interfaces for the unit
interface rar_in_if #(parameter int W = 32);
    logic          valid;
    logic          ready;
    logic [1:0]    mode;
    logic signed [W-1:0] a_num;
    logic signed [W-1:0] a_den;
    logic signed [W-1:0] b_num;
    logic signed [W-1:0] b_den;
    modport source (output valid, mode, a_num, a_den, b_num, b_den, input ready);
    modport sink (input valid, mode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rar_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] res_num;
    logic [62:0]        res_den;
    modport source (output valid, res_num, res_den, input ready);
    modport sink (input valid, res_num, res_den, output ready);
endinterface

/* design/rational_arith_reduce_unit.sv */
// top level of the rational arithmetic reduce unit
// the back end strips the common factors of two (at most 62), runs the binary gcd steps
// and two divisions; a zero result goes straight to its shown output
// the back end takes a new job only once its last result is taken; front and back overlap
// through a two-entry queue
// reset: synchronous active low, clears control state and empties the queue
module rational_arith_reduce_unit #(
    parameter int OPERAND_WIDTH = rar_pkg::OperandWidth
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rar_in_if.sink    i_req,
    rar_out_if.source o_res
);
    logic          job_valid, job_ready, q_valid, q_ready;
    rar_pkg::t_job job, q_job;

    rar_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(i_req.valid), .o_ready(i_req.ready),
        .i_mode(i_req.mode),
        .i_a_num(i_req.a_num[OPERAND_WIDTH-1:0]), .i_a_den(i_req.a_den[OPERAND_WIDTH-1:0]),
        .i_b_num(i_req.b_num[OPERAND_WIDTH-1:0]), .i_b_den(i_req.b_den[OPERAND_WIDTH-1:0]),
        .o_job_valid(job_valid), .i_job_ready(job_ready), .o_job(job)
    );

    rar_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(job_valid), .o_ready(job_ready), .i_data(job),
        .o_valid(q_valid), .i_ready(q_ready), .o_data(q_job)
    );

    rar_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_ready(q_ready), .i_job(q_job),
        .o_valid(o_res.valid), .i_ready(o_res.ready),
        .o_res_num(o_res.res_num), .o_res_den(o_res.res_den)
    );
endmodule

/* design/rar_front.sv */
// front end: accepts requests, forms cross products, classifies zero results
module rar_front #(
    parameter int OPERAND_WIDTH = rar_pkg::OperandWidth
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_mode,
    input  logic [OPERAND_WIDTH-1:0]   i_a_num,
    input  logic [OPERAND_WIDTH-1:0]   i_a_den,
    input  logic [OPERAND_WIDTH-1:0]   i_b_num,
    input  logic [OPERAND_WIDTH-1:0]   i_b_den,
    output logic                       o_job_valid,
    input  logic                       i_job_ready,
    output rar_pkg::t_job              o_job
);
    localparam int W = OPERAND_WIDTH;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL1 = 4'b0010,
        S_MUL2 = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [1:0]   r_mode;
    logic [W-1:0] r_mag [4];   // an, ad, bn, bd magnitudes
    logic [3:0]   r_sgn;
    logic [63:0]  r_p1, r_p2, r_p3;
    logic         r_s1, r_s2, r_s3;
    rar_pkg::t_job r_job;

    // magnitude of each operand
    function automatic logic [W-1:0] mag_of(input logic [W-1:0] x);
        return x[W-1] ? (~x + 1'b1) : x;
    endfunction

    logic [W-1:0] m_a, m_b, m_c, m_d;
    logic [63:0]  prod1, prod2;
    logic         s_a, s_b, s_c, s_d;

    // operand selection per phase: one product pair per cycle
    always_comb begin
        m_a = r_mag[0]; s_a = r_sgn[0];
        m_b = r_mag[3]; s_b = r_sgn[3];
        m_c = r_mag[1]; s_c = r_sgn[1];
        m_d = r_mag[3]; s_d = r_sgn[3];
        case (rar_pkg::t_mode'(r_mode))
            rar_pkg::MODE_MUL: begin
                m_b = r_mag[2]; s_b = r_sgn[2];
            end
            rar_pkg::MODE_DIV: begin
                m_d = r_mag[2]; s_d = r_sgn[2];
            end
            default: begin
            end
        endcase
        if (r_state == S_MUL2) begin
            // bn * ad for add and subtract
            m_a = r_mag[2]; s_a = r_sgn[2] ^ (r_mode == rar_pkg::MODE_SUB);
            m_b = r_mag[1]; s_b = r_sgn[1];
        end
    end

    assign prod1 = 64'(m_a) * 64'(m_b);
    assign prod2 = 64'(m_c) * 64'(m_d);

    // signed magnitude add of numerator terms
    logic [63:0] sum_mag;
    logic        sum_neg;
    always_comb begin
        if (r_s1 == r_s3) begin
            sum_mag = r_p1 + r_p3;
            sum_neg = r_s1;
        end else if (r_p1 >= r_p3) begin
            sum_mag = r_p1 - r_p3;
            sum_neg = r_s1;
        end else begin
            sum_mag = r_p3 - r_p1;
            sum_neg = r_s3;
        end
    end

    logic is_addsub;
    assign is_addsub = (r_mode == rar_pkg::MODE_ADD) || (r_mode == rar_pkg::MODE_SUB);

    // sequencing
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid) n_state = S_MUL1;
            S_MUL1: n_state = is_addsub ? S_MUL2 : S_OUT;
            S_MUL2: n_state = S_OUT;
            S_OUT:  if (i_job_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // operand and product registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_mode   <= i_mode;
            r_mag[0] <= mag_of(i_a_num); r_sgn[0] <= i_a_num[W-1];
            r_mag[1] <= mag_of(i_a_den); r_sgn[1] <= i_a_den[W-1];
            r_mag[2] <= mag_of(i_b_num); r_sgn[2] <= i_b_num[W-1];
            r_mag[3] <= mag_of(i_b_den); r_sgn[3] <= i_b_den[W-1];
        end
        if (r_state == S_MUL1) begin
            r_p1 <= prod1; r_s1 <= s_a ^ s_b;
            r_p2 <= prod2; r_s2 <= s_c ^ s_d;
            r_p3 <= '0;    r_s3 <= 1'b0;
        end
        if (r_state == S_MUL2) begin
            r_p3 <= prod1; r_s3 <= s_a ^ s_b;
        end
    end

    // result classification
    always_comb begin
        r_job.num_mag = is_addsub ? sum_mag : r_p1;
        r_job.den_mag = r_p2;
        r_job.zero    = (r_job.num_mag == '0) || (r_p2 == '0);
        r_job.neg     = (is_addsub ? sum_neg : r_s1) ^ r_s2;
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_job_valid = (r_state == S_OUT);
    assign o_job       = r_job;
endmodule

/* design/rar_queue.sv */
// two-entry queue between front and back
module rar_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  rar_pkg::t_job i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output rar_pkg::t_job o_data
);
    rar_pkg::t_job r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_data;
    end
endmodule

/* design/rar_back.sv */
// back end: binary gcd and two restoring divisions, one bit per cycle
module rar_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  rar_pkg::t_job      i_job,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [63:0] o_res_num,
    output logic [62:0]        o_res_den
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SHIFT = 6'b000010,
        S_GCD   = 6'b000100,
        S_DIVN  = 6'b001000,
        S_DIVD  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic        r_neg;
    logic [63:0] r_n, r_d;      // original magnitudes
    logic [63:0] r_u, r_v;      // gcd working pair
    logic [5:0]  r_k;           // common power of two
    logic [63:0] r_g;
    logic [63:0] r_q, r_rem;
    logic [5:0]  r_bit;
    logic [63:0] r_qn;
    logic signed [63:0] r_res_num;
    logic [62:0] r_res_den;

    // divider step: shift in one dividend bit
    logic [64:0] trial;
    logic [63:0] dvd;
    assign dvd   = (r_state == S_DIVN) ? r_n : r_d;
    assign trial = {r_rem, dvd[r_bit]} - {1'b0, r_g};

    logic [63:0] u_diff;
    assign u_diff = (r_u > r_v) ? (r_u - r_v) : (r_v - r_u);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = i_job.zero ? S_OUT : S_SHIFT;
            S_SHIFT: if (r_u[0] || r_v[0]) n_state = S_GCD;
            S_GCD:   if (r_u == r_v) n_state = S_DIVN;
            S_DIVN:  if (r_bit == '0) n_state = S_DIVD;
            S_DIVD:  if (r_bit == '0) n_state = S_OUT;
            S_OUT:   if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_neg <= i_job.neg;
                r_n <= i_job.num_mag; r_d <= i_job.den_mag;
                r_u <= i_job.num_mag; r_v <= i_job.den_mag;
                r_k <= '0;
                r_res_num <= 64'sd0;
                r_res_den <= 63'd1;
            end
            S_SHIFT: begin
                if (!(r_u[0] || r_v[0])) begin
                    r_u <= r_u >> 1; r_v <= r_v >> 1; r_k <= r_k + 6'd1;
                end
            end
            S_GCD: begin
                // strip factors of two, then subtract smaller from larger
                if (r_u == r_v) begin
                    r_g <= r_u << r_k;
                    r_bit <= 6'd63; r_rem <= '0; r_q <= '0;
                end else if (!r_u[0]) begin
                    r_u <= r_u >> 1;
                end else if (!r_v[0]) begin
                    r_v <= r_v >> 1;
                end else if (r_u > r_v) begin
                    r_u <= u_diff;
                end else begin
                    r_v <= u_diff;
                end
            end
            S_DIVN, S_DIVD: begin
                r_bit <= r_bit - 6'd1;
                if (r_bit == '0 && r_state == S_DIVN) begin
                    r_qn  <= {r_q[62:0], !trial[64]};
                    r_rem <= '0; r_q <= '0;
                end else if (!trial[64]) begin
                    r_rem <= trial[63:0];
                    r_q   <= {r_q[62:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[62:0], dvd[r_bit]};
                    r_q   <= {r_q[62:0], 1'b0};
                end
                if (r_bit == '0 && r_state == S_DIVD) begin
                    r_res_num <= r_neg ? -$signed(r_qn) : $signed(r_qn);
                    r_res_den <= {r_q[61:0], !trial[64]};
                end
            end
            default: begin
            end
        endcase
    end

    assign o_ready   = (r_state == S_IDLE);
    assign o_valid   = (r_state == S_OUT);
    assign o_res_num = r_res_num;
    assign o_res_den = r_res_den;
endmodule

/* design/rar_checker.sv */
// port-level checker for the rational arithmetic reduce unit
module rar_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [63:0] i_res_num,
    input logic [62:0]        i_res_den
);
    // denominator is never zero on a shown result
    a_den_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_res_den != '0) else $error("zero denominator");

    // a zero numerator comes with denominator one
    a_zero_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_res_num == 0 |-> i_res_den == 63'd1) else $error("zero not 0/1");

    // stalled result stays valid with its numerator held
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_res_num))
        else $error("result dropped");

    // no result in the cycle right after a taken one
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready |=> !i_out_valid) else $error("back-to-back result");
endmodule

bind rational_arith_reduce_unit rar_checker u_rar_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_out_valid(o_res.valid), .i_out_ready(o_res.ready),
    .i_res_num(o_res.res_num), .i_res_den(o_res.res_den)
);

/* test/testbench.sv */
// testbench for the rational arithmetic reduce unit: directed and random requests, checked by a predictor
`timescale 1ns / 1ps

module testbench;
    typedef struct {
        logic signed [63:0] num;
        logic [62:0]        den;
    } t_frac;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int unsigned cycle_count = 0;
    int unsigned error_count = 0;
    bit hold_off = 1'b0;
    t_frac expected_fracs[$];

    rar_in_if #(.W(32)) req_if ();
    rar_out_if res_if ();

    rational_arith_reduce_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_res  (res_if.source)
    );

    // clock and run limit
    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 1500000) begin
            $display("** rational_arith_reduce_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        req_if.valid = 1'b0;
        req_if.mode = rar_pkg::MODE_ADD;
        req_if.a_num = '0;
        req_if.a_den = '0;
        req_if.b_num = '0;
        req_if.b_den = '0;
        res_if.ready = 1'b0;
    end

    // magnitude of one 32-bit operand, zero-extended to 64 bits
    function automatic logic [63:0] mag_of(logic signed [31:0] x);
        logic [31:0] m;
        m = x[31] ? (~x + 32'd1) : x;
        return {32'd0, m};
    endfunction

    function automatic logic [63:0] gcd_of(logic [63:0] x, logic [63:0] y);
        logic [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // exact reduced fraction of one request
    function automatic t_frac reduce_frac(rar_pkg::t_mode mode, logic signed [31:0] an,
                                          logic signed [31:0] ad, logic signed [31:0] bn,
                                          logic signed [31:0] bd);
        logic [63:0] p_mag, q_mag, num_mag, den_mag, g;
        logic p_neg, q_neg, num_neg, den_neg, neg;
        t_frac r;
        case (mode)
            rar_pkg::MODE_MUL: begin
                num_mag = mag_of(an) * mag_of(bn);
                num_neg = an[31] ^ bn[31];
                den_mag = mag_of(ad) * mag_of(bd);
                den_neg = ad[31] ^ bd[31];
            end
            rar_pkg::MODE_DIV: begin
                num_mag = mag_of(an) * mag_of(bd);
                num_neg = an[31] ^ bd[31];
                den_mag = mag_of(ad) * mag_of(bn);
                den_neg = ad[31] ^ bn[31];
            end
            default: begin
                p_mag = mag_of(an) * mag_of(bd);
                p_neg = (an[31] ^ bd[31]) && p_mag != 0;
                q_mag = mag_of(bn) * mag_of(ad);
                q_neg = (bn[31] ^ ad[31]) && q_mag != 0;
                if (mode == rar_pkg::MODE_SUB) q_neg = !q_neg && q_mag != 0;
                if (p_neg == q_neg) begin
                    num_mag = p_mag + q_mag;
                    num_neg = p_neg;
                end else if (p_mag >= q_mag) begin
                    num_mag = p_mag - q_mag;
                    num_neg = p_neg;
                end else begin
                    num_mag = q_mag - p_mag;
                    num_neg = q_neg;
                end
                den_mag = mag_of(ad) * mag_of(bd);
                den_neg = ad[31] ^ bd[31];
            end
        endcase
        if (num_mag == 0 || den_mag == 0) begin
            r.num = 64'sd0;
            r.den = 63'd1;
            return r;
        end
        neg = num_neg ^ den_neg;
        g = gcd_of(num_mag, den_mag);
        num_mag = num_mag / g;
        den_mag = den_mag / g;
        r.num = neg ? (64'd0 - num_mag) : num_mag;
        r.den = den_mag[62:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    // send one request after a random gap; valid stays up until the next gap or drain
    task automatic send_request(rar_pkg::t_mode mode, logic signed [31:0] an,
                                logic signed [31:0] ad, logic signed [31:0] bn,
                                logic signed [31:0] bd);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.mode <= mode;
        req_if.a_num <= an;
        req_if.a_den <= ad;
        req_if.b_num <= bn;
        req_if.b_den <= bd;
        expected_fracs.push_back(reduce_frac(mode, an, ad, bn, bd));
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    // result receiver with random stalls
    initial begin
        int stall;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = $urandom_range(0, 3);
            while (hold_off || stall > 0) begin
                res_if.ready <= 1'b0;
                @(posedge i_clk);
                if (stall > 0) stall--;
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_if.valid) @(posedge i_clk);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_frac want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_fracs.size() == 0) begin
                report_mismatch("unexpected result", res_if.res_num, 64'd0);
            end else begin
                want = expected_fracs.pop_front();
                if (res_if.res_num !== want.num)
                    report_mismatch("numerator", res_if.res_num, want.num);
                if (res_if.res_den !== want.den)
                    report_mismatch("denominator", {1'b0, res_if.res_den}, {1'b0, want.den});
            end
        end
    end

    function automatic logic signed [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return $signed(32'($urandom_range(0, 12)) - 32'sd6);
            1: return $signed($urandom());
            2: return 32'sh8000_0000 + 32'($urandom_range(0, 2));
            3: return 32'sh7fff_ffff - 32'($urandom_range(0, 2));
            4: return $signed(32'($urandom_range(0, 2000)) - 32'sd1000);
            default: return $signed(32'($urandom() >> $urandom_range(0, 31)));
        endcase
    endfunction

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (expected_fracs.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_request(rar_pkg::MODE_ADD, 1, 2, 1, 3);
        send_request(rar_pkg::MODE_SUB, 1, 2, 1, 2);
        send_request(rar_pkg::MODE_MUL, -3, 4, 8, -9);
        send_request(rar_pkg::MODE_DIV, 2, 3, 4, 5);
        send_request(rar_pkg::MODE_ADD, 5, 0, 1, 1);
        send_request(rar_pkg::MODE_MUL, 5, 1, 1, 0);
        send_request(rar_pkg::MODE_DIV, 7, 3, 0, 5);
        send_request(rar_pkg::MODE_DIV, 7, 3, 1, 0);
        send_request(rar_pkg::MODE_SUB, 0, 1, 0, 1);
        send_request(rar_pkg::MODE_ADD, 6, -4, 0, 1);
        send_request(rar_pkg::MODE_MUL, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 1);
        send_request(rar_pkg::MODE_MUL, 32'sh8000_0000, 1, 32'sh8000_0000, 1);
        send_request(rar_pkg::MODE_DIV, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 1);
        send_request(rar_pkg::MODE_ADD, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                     32'sh7fff_ffff);
        send_request(rar_pkg::MODE_SUB, 32'sh8000_0000, 1, 32'sh7fff_ffff, 1);
        send_request(rar_pkg::MODE_ADD, -1, -1, -1, -1);
        send_request(rar_pkg::MODE_SUB, 32'sh7fff_ffff, 32'sh8000_0000, 1, 32'sh7fff_ffff);
        send_request(rar_pkg::MODE_MUL, 12, 18, 15, 10);
        send_request(rar_pkg::MODE_DIV, -1, 1, -1, -1);
        send_request(rar_pkg::MODE_ADD, 3, 1, 4, 1);
    endtask

    task automatic test_random(int count);
        repeat (count)
            send_request(rar_pkg::t_mode'($urandom_range(0, 3)), rand_operand(),
                         rand_operand(), rand_operand(), rand_operand());
    endtask

    // receiver holds off while the sender keeps offering, filling the queue
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (3000) @(posedge i_clk);
                hold_off = 1'b0;
            end
            test_random(8);
        join
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        wait_drained();
        test_random(400);
        wait_drained();
        test_backpressure();
        test_random(420);
        wait_drained();
        repeat (400) @(posedge i_clk);
        if (error_count == 0) begin
            $display("** rational_arith_reduce_unit: PASSED **");
        end else begin
            $display("** rational_arith_reduce_unit: FAILED **");
        end
        $finish;
    end
endmodule
